// ----- rtl/core/ffpa_pkg.sv -----
// Shared types and constants for the first-fit partition allocator.
`timescale 1ns / 1ps

package ffpa_pkg;

    localparam int NUM_PARTS_DEF = 8;
    localparam int SIZE_BITS_DEF = 16;

    localparam int MODE_W      = 2;
    localparam int FSIZE_W     = 16;
    localparam int FINDEX_W    = 8;
    localparam int STATUS_W    = 2;
    localparam int GRANT_W     = 3;
    localparam int MAP_W       = 8;
    localparam int PCOUNT_W    = 4;
    // holds an effective partition count; 7 bits hold values up to 127
    localparam int CNT_W       = 7;
    localparam int QUEUE_DEPTH = 2;

    localparam logic [PCOUNT_W-1:0] PART_COUNT_RESET = 4'd8;

    localparam logic [MODE_W-1:0] MODE_ALLOC = 2'd0;
    localparam logic [MODE_W-1:0] MODE_FREE  = 2'd1;
    localparam logic [MODE_W-1:0] MODE_LOAD  = 2'd2;

    localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_NOFIT = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_RANGE = 2'd2;

    typedef enum logic [2:0] {
        OP_ALLOC,
        OP_FREE,
        OP_LOAD,
        OP_NOP,
        OP_RANGE
    } op_kind_t;

    typedef enum logic {
        BK_IDLE,
        BK_SCAN
    } back_state_t;

    typedef struct packed {
        logic [MODE_W-1:0]   mode;
        logic [FSIZE_W-1:0]  request_size;
        logic [FINDEX_W-1:0] part_index;
        logic [FSIZE_W-1:0]  part_size;
    } cmd_t;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [GRANT_W-1:0]  granted_index;
        logic [MAP_W-1:0]    alloc_map;
    } result_t;

    // classified request handed from front to back
    typedef struct packed {
        op_kind_t            kind;
        logic [CNT_W-1:0]    count;
        logic [FINDEX_W-1:0] part_index;
        logic [FSIZE_W-1:0]  request_size;
        logic [FSIZE_W-1:0]  part_size;
    } work_t;

endpackage

// ----- rtl/core/ffpa_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module ffpa_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 8
) (
    input  logic                                     clk,
    input  logic                                     we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                         wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata <= mem_reg[raddr];
    end

endmodule

// ----- rtl/core/ffpa_front.sv -----
// Front end: takes requests, classifies them, feeds the work queue.
`timescale 1ns / 1ps

module ffpa_front #(
    parameter int NUM_PARTS = ffpa_pkg::NUM_PARTS_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    input  ffpa_pkg::cmd_t                  cmd,
    input  logic [ffpa_pkg::PCOUNT_W-1:0]   part_count,
    input  logic                            q_full,
    output logic                            busy,
    output logic                            q_push,
    output ffpa_pkg::work_t                 q_item
);

    logic                          hold_valid_reg;
    logic                          hold_valid_next;
    ffpa_pkg::work_t               hold_reg;
    ffpa_pkg::work_t               hold_next;
    ffpa_pkg::work_t               classified;
    logic [ffpa_pkg::CNT_W-1:0]    eff_count;
    logic                          in_range;
    logic                          accept;

    // part_count above NUM_PARTS is clamped
    assign eff_count = (ffpa_pkg::CNT_W'(part_count) > ffpa_pkg::CNT_W'(NUM_PARTS))
                     ? ffpa_pkg::CNT_W'(NUM_PARTS) : ffpa_pkg::CNT_W'(part_count);
    assign in_range  = cmd.part_index < ffpa_pkg::FINDEX_W'(eff_count);

    always_comb
    begin
        classified.count        = eff_count;
        classified.part_index   = cmd.part_index;
        classified.request_size = cmd.request_size;
        classified.part_size    = cmd.part_size;
        case (cmd.mode)
            ffpa_pkg::MODE_ALLOC: classified.kind = ffpa_pkg::OP_ALLOC;
            ffpa_pkg::MODE_FREE:  classified.kind = in_range ? ffpa_pkg::OP_FREE
                                                             : ffpa_pkg::OP_RANGE;
            ffpa_pkg::MODE_LOAD:  classified.kind = in_range ? ffpa_pkg::OP_LOAD
                                                             : ffpa_pkg::OP_RANGE;
            default:              classified.kind = ffpa_pkg::OP_NOP;
        endcase
    end

    assign q_push = hold_valid_reg && !q_full;
    assign q_item = hold_reg;
    assign busy   = hold_valid_reg && q_full;
    assign accept = start && !busy;

    always_comb
    begin
        hold_valid_next = hold_valid_reg;
        hold_next       = hold_reg;
        if (q_push)
        begin
            hold_valid_next = 1'b0;
        end
        if (accept)
        begin
            hold_valid_next = 1'b1;
            hold_next       = classified;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_valid_reg <= 1'b0;
        end
        else
        begin
            hold_valid_reg <= hold_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        hold_reg <= hold_next;
    end

endmodule

// ----- rtl/core/ffpa_queue.sv -----
// Short FIFO of classified requests between front and back.
`timescale 1ns / 1ps

module ffpa_queue #(
    parameter int DEPTH = ffpa_pkg::QUEUE_DEPTH
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  ffpa_pkg::work_t   push_item,
    input  logic              pop,
    output logic              full,
    output logic              not_empty,
    output ffpa_pkg::work_t   head
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int FILL_W = $clog2(DEPTH + 1);

    ffpa_pkg::work_t     slot_reg [DEPTH];
    logic [PTR_W-1:0]    wr_ptr_reg;
    logic [PTR_W-1:0]    wr_ptr_next;
    logic [PTR_W-1:0]    rd_ptr_reg;
    logic [PTR_W-1:0]    rd_ptr_next;
    logic [FILL_W-1:0]   fill_reg;
    logic [FILL_W-1:0]   fill_next;

    assign full      = fill_reg == FILL_W'(DEPTH);
    assign not_empty = fill_reg != '0;
    assign head      = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        fill_next   = fill_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            fill_next = fill_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            fill_next = fill_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

// ----- rtl/core/ffpa_back.sv -----
// Back end: size table, allocation bitmap, first-fit scan and result register.
`timescale 1ns / 1ps

module ffpa_back #(
    parameter int NUM_PARTS = ffpa_pkg::NUM_PARTS_DEF,
    parameter int SIZE_BITS = ffpa_pkg::SIZE_BITS_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 q_valid,
    input  ffpa_pkg::work_t      q_item,
    output logic                 q_pop,
    output logic                 done,
    output ffpa_pkg::result_t    result
);

    localparam int IDX_W = (NUM_PARTS > 1) ? $clog2(NUM_PARTS) : 1;

    ffpa_pkg::back_state_t   state_reg;
    ffpa_pkg::back_state_t   state_next;
    ffpa_pkg::work_t         cur_reg;
    ffpa_pkg::work_t         cur_next;
    logic [IDX_W-1:0]        rd_idx_reg;
    logic [IDX_W-1:0]        rd_idx_next;
    logic [NUM_PARTS-1:0]    alloc_reg;
    logic [NUM_PARTS-1:0]    alloc_next;
    logic [NUM_PARTS-1:0]    valid_reg;
    logic [NUM_PARTS-1:0]    valid_next;
    logic                    done_reg;
    logic                    done_next;
    ffpa_pkg::result_t       res_reg;
    ffpa_pkg::result_t       res_next;

    logic                    ram_we;
    logic [IDX_W-1:0]        ram_waddr;
    logic [SIZE_BITS-1:0]    ram_wdata;
    logic [IDX_W-1:0]        ram_raddr;
    logic [SIZE_BITS-1:0]    ram_rdata;
    logic [SIZE_BITS-1:0]    entry_size;
    logic [SIZE_BITS-1:0]    req_size;
    logic                    hit;
    logic                    last;
    logic [IDX_W-1:0]        q_idx;

    ffpa_ram #(
        .WIDTH (SIZE_BITS),
        .DEPTH (NUM_PARTS)
    ) u_size_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // never-loaded entries read as zero
    assign entry_size = valid_reg[rd_idx_reg] ? ram_rdata : '0;
    assign req_size   = SIZE_BITS'(cur_reg.request_size);
    assign hit        = !alloc_reg[rd_idx_reg] && (entry_size >= req_size);
    assign last       = (ffpa_pkg::CNT_W'(rd_idx_reg) + 1'b1) >= cur_reg.count;
    assign q_idx      = q_item.part_index[IDX_W-1:0];

    assign ram_waddr  = q_idx;
    assign ram_wdata  = SIZE_BITS'(q_item.part_size);

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ffpa_pkg::BK_IDLE:
            begin
                if (q_valid && q_item.kind == ffpa_pkg::OP_ALLOC && q_item.count != '0)
                begin
                    state_next = ffpa_pkg::BK_SCAN;
                end
            end
            ffpa_pkg::BK_SCAN:
            begin
                if (hit || last)
                begin
                    state_next = ffpa_pkg::BK_IDLE;
                end
            end
            default: state_next = ffpa_pkg::BK_IDLE;
        endcase
    end

    always_comb
    begin
        q_pop       = 1'b0;
        ram_we      = 1'b0;
        ram_raddr   = '0;
        cur_next    = cur_reg;
        rd_idx_next = rd_idx_reg;
        alloc_next  = alloc_reg;
        valid_next  = valid_reg;
        done_next   = 1'b0;
        res_next    = res_reg;
        res_next.status        = ffpa_pkg::STATUS_OK;
        res_next.granted_index = '0;
        case (state_reg)
            ffpa_pkg::BK_IDLE:
            begin
                if (q_valid)
                begin
                    q_pop       = 1'b1;
                    cur_next    = q_item;
                    rd_idx_next = '0;
                    case (q_item.kind)
                        ffpa_pkg::OP_ALLOC:
                        begin
                            // no partitions in use: nothing to scan
                            if (q_item.count == '0)
                            begin
                                done_next       = 1'b1;
                                res_next.status = ffpa_pkg::STATUS_NOFIT;
                            end
                        end
                        ffpa_pkg::OP_FREE:
                        begin
                            alloc_next[q_idx] = 1'b0;
                            done_next         = 1'b1;
                        end
                        ffpa_pkg::OP_LOAD:
                        begin
                            ram_we            = 1'b1;
                            valid_next[q_idx] = 1'b1;
                            alloc_next[q_idx] = 1'b0;
                            done_next         = 1'b1;
                        end
                        ffpa_pkg::OP_RANGE:
                        begin
                            done_next       = 1'b1;
                            res_next.status = ffpa_pkg::STATUS_RANGE;
                        end
                        default:
                        begin
                            done_next = 1'b1;
                        end
                    endcase
                end
            end
            ffpa_pkg::BK_SCAN:
            begin
                // prefetch the next entry while this one is checked
                ram_raddr   = rd_idx_reg + 1'b1;
                rd_idx_next = rd_idx_reg + 1'b1;
                if (hit)
                begin
                    alloc_next[rd_idx_reg] = 1'b1;
                    done_next              = 1'b1;
                    res_next.granted_index = ffpa_pkg::GRANT_W'(rd_idx_reg);
                end
                else if (last)
                begin
                    done_next       = 1'b1;
                    res_next.status = ffpa_pkg::STATUS_NOFIT;
                end
            end
            default:
            begin
                done_next = 1'b0;
            end
        endcase
        res_next.alloc_map = ffpa_pkg::MAP_W'(alloc_next);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ffpa_pkg::BK_IDLE;
            alloc_reg <= '0;
            valid_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            alloc_reg <= alloc_next;
            valid_reg <= valid_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg    <= cur_next;
        rd_idx_reg <= rd_idx_next;
        res_reg    <= res_next;
    end

    assign done   = done_reg;
    assign result = res_reg;

    a_scan_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ffpa_pkg::BK_SCAN |-> ffpa_pkg::CNT_W'(rd_idx_reg) < cur_reg.count)
        else $error("scan index past partition count");

    a_scan_ends_in_result: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ffpa_pkg::BK_SCAN && (hit || last)) |=> done_reg)
        else $error("finished scan gave no result");

    a_valid_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        1'b1 |=> (($past(valid_reg) & ~valid_reg) == '0))
        else $error("loaded size entry lost its valid bit");

    a_grant_marked: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ffpa_pkg::BK_SCAN && hit) |=> alloc_reg[$past(rd_idx_reg)])
        else $error("granted partition not marked allocated");

endmodule

// ----- rtl/core/first_fit_partition_allocator_core.sv -----
// Top level of the first-fit fixed-partition allocator.
`timescale 1ns / 1ps
// Path: free, load, no-op and out-of-range requests pass through the front hold register,
//   the queue and the back end's result register; an allocate also scans 1..count entries.
// Throughput: one non-allocate request per cycle while no allocate scan is running;
//   an allocate holds the back end while it scans the size RAM one entry per cycle.
// Reset clears the bitmap, the size-table valid bits and the queue; part_count = 8.
// Results come out as a one-cycle done strobe; the receiver cannot stall them.

module first_fit_partition_allocator_core #(
    parameter int NUM_PARTS = ffpa_pkg::NUM_PARTS_DEF,
    parameter int SIZE_BITS = ffpa_pkg::SIZE_BITS_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    // request side
    input  logic                            start,
    input  ffpa_pkg::cmd_t                  cmd,
    output logic                            busy,
    // result side
    output logic                            done,
    output ffpa_pkg::result_t               result,
    // partition count register
    input  logic                            cfg_we,
    input  logic [ffpa_pkg::PCOUNT_W-1:0]   cfg_data
);

    logic [ffpa_pkg::PCOUNT_W-1:0] part_count_reg;
    logic [ffpa_pkg::PCOUNT_W-1:0] part_count_next;

    logic             q_push;
    logic             q_pop;
    logic             q_full;
    logic             q_not_empty;
    ffpa_pkg::work_t  q_in;
    ffpa_pkg::work_t  q_head;

    // The user must write config only while idle, so requests in flight see a
    // stable count; the block itself does not enforce it.
    assign part_count_next = cfg_we ? cfg_data : part_count_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            part_count_reg <= ffpa_pkg::PART_COUNT_RESET;
        end
        else
        begin
            part_count_reg <= part_count_next;
        end
    end

    // Front: clamps the count, range-checks the index, decodes the mode.
    ffpa_front #(
        .NUM_PARTS (NUM_PARTS)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .cmd        (cmd),
        .part_count (part_count_reg),
        .q_full     (q_full),
        .busy       (busy),
        .q_push     (q_push),
        .q_item     (q_in)
    );

    // Decoupling queue: front keeps accepting while the back end scans, until the queue and front hold register fill.
    ffpa_queue #(
        .DEPTH (ffpa_pkg::QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_item (q_in),
        .pop       (q_pop),
        .full      (q_full),
        .not_empty (q_not_empty),
        .head      (q_head)
    );

    // Back: owns the size RAM and bitmap, runs the first-fit scan.
    ffpa_back #(
        .NUM_PARTS (NUM_PARTS),
        .SIZE_BITS (SIZE_BITS)
    ) u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_valid (q_not_empty),
        .q_item  (q_head),
        .q_pop   (q_pop),
        .done    (done),
        .result  (result)
    );

endmodule
